// ===== src/lcdnw_pkg.sv =====
// Shared types and constants for the LCD 4-bit write sequencer.
// No dependencies.
`default_nettype none

package lcdnw_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CMD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHAR = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_LOC  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 1'b1;

  localparam logic [TICK_W-1:0] PULSE_TICKS_RST  = 16'd1000;
  localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 16'd5000;

  localparam logic [BYTE_W-1:0] ADDR_ROW0 = 8'h80;
  localparam logic [BYTE_W-1:0] ADDR_ROW1 = 8'hC0;

  typedef struct packed {
    logic              reg_select;
    logic              read_write;
    logic              enable;
    logic [NIB_W-1:0]  data_nibble;
    logic              busy_res;
    logic              rejected;
  } lcdnw_pins_t;

endpackage

`default_nettype wire

// ===== src/lcdnw_loc.sv =====
// Cursor location to set-DDRAM-address command byte.
// Depends on lcdnw_pkg.
`default_nettype none

module lcdnw_loc #(
  parameter int unsigned ROW_LENGTH = 16
) (
  input  wire logic [lcdnw_pkg::ROW_W-1:0]  row,
  input  wire logic [lcdnw_pkg::COL_W-1:0]  column,
  output logic      [lcdnw_pkg::BYTE_W-1:0] addr_byte
);
  import lcdnw_pkg::*;

  logic [COL_W:0]  col_ext;
  logic [BYTE_W-1:0] col_used;

  assign col_ext  = {1'b0, column};
  assign col_used = (col_ext < (COL_W+1)'(ROW_LENGTH)) ? BYTE_W'(column) : '0;

  always_comb begin
    unique case (row)
      2'd0:    addr_byte = ADDR_ROW0 + col_used;
      2'd1:    addr_byte = ADDR_ROW1 + col_used;
      default: addr_byte = ADDR_ROW0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/lcdnw_core.sv =====
// Write sequencer state and one-tick step: phase, tick counter, held byte.
// Depends on lcdnw_pkg and lcdnw_loc.
`default_nettype none

module lcdnw_core #(
  parameter int unsigned ROW_LENGTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step_en,
  input  wire logic [lcdnw_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic [lcdnw_pkg::BYTE_W-1:0]    value,
  input  wire logic [lcdnw_pkg::ROW_W-1:0]     row,
  input  wire logic [lcdnw_pkg::COL_W-1:0]     column,
  input  wire logic [lcdnw_pkg::TICK_W-1:0]    pulse_ticks,
  input  wire logic [lcdnw_pkg::TICK_W-1:0]    settle_ticks,
  output lcdnw_pkg::lcdnw_pins_t               pins
);
  import lcdnw_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HIGH   = 2'd1;
  localparam logic [1:0] PH_LOW    = 2'd2;
  localparam logic [1:0] PH_SETTLE = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic [BYTE_W-1:0] held_byte_r, held_byte_nxt;
  logic              held_select_r, held_select_nxt;

  logic [BYTE_W-1:0] loc_byte;
  logic [TICK_W-1:0] pt, st;
  logic [TICK_W:0]   cnt_inc;

  lcdnw_loc #(.ROW_LENGTH(ROW_LENGTH)) u_loc (
    .row       (row),
    .column    (column),
    .addr_byte (loc_byte)
  );

  assign pt      = (pulse_ticks == '0) ? TICK_W'(1) : pulse_ticks;
  assign st      = (settle_ticks == '0) ? TICK_W'(1) : settle_ticks;
  assign cnt_inc = {1'b0, tick_count_r} + (TICK_W+1)'(1);

  always_comb begin
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    held_byte_nxt    = held_byte_r;
    held_select_nxt  = held_select_r;
    pins.read_write  = 1'b0;
    pins.enable      = 1'b0;
    pins.busy_res    = 1'b1;
    pins.rejected    = 1'b0;
    pins.data_nibble = held_byte_r[NIB_W-1:0];

    unique case (phase_r)
      PH_IDLE: begin
        if (opcode == OP_TICK) begin
          pins.busy_res = 1'b0;
        end else begin
          held_byte_nxt    = (opcode == OP_LOC) ? loc_byte : value;
          held_select_nxt  = (opcode == OP_CHAR);
          pins.data_nibble = held_byte_nxt[BYTE_W-1:NIB_W];
          phase_nxt        = PH_HIGH;
          tick_count_nxt   = '0;
        end
      end
      PH_HIGH: begin
        pins.rejected    = (opcode != OP_TICK);
        pins.enable      = 1'b1;
        pins.data_nibble = held_byte_r[BYTE_W-1:NIB_W];
        if (cnt_inc >= {1'b0, pt}) begin
          phase_nxt      = PH_LOW;
          tick_count_nxt = '0;
        end else begin
          tick_count_nxt = cnt_inc[TICK_W-1:0];
        end
      end
      PH_LOW: begin
        pins.rejected = (opcode != OP_TICK);
        pins.enable   = (tick_count_r != '0);
        if (tick_count_r >= pt) begin
          phase_nxt      = PH_SETTLE;
          tick_count_nxt = '0;
        end else begin
          tick_count_nxt = cnt_inc[TICK_W-1:0];
        end
      end
      default: begin
        pins.rejected = (opcode != OP_TICK);
        if (cnt_inc >= {1'b0, st}) begin
          phase_nxt      = PH_IDLE;
          tick_count_nxt = '0;
        end else begin
          tick_count_nxt = cnt_inc[TICK_W-1:0];
        end
      end
    endcase

    pins.reg_select = held_select_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      held_byte_r   <= '0;
      held_select_r <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      held_byte_r   <= held_byte_nxt;
      held_select_r <= held_select_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/lcd_nibble_write_sequencer.sv =====
// LCD 4-bit write sequencer top level: input register, step core, result register,
// timing registers. Depends on lcdnw_pkg and lcdnw_core.
//
// Usage: every input word is one tick of the LCD sequence. Opcode 0 only advances
// time; opcodes 1, 2 and 3 request a command byte, a character byte or a cursor
// address. Each accepted word yields exactly one result word holding the pin levels
// (reg_select, read_write, enable, data_nibble) for that tick plus busy and reject
// flags. A request that lands while a transfer or settle is running is dropped and
// flagged in its own result word.
// The result word passes through the input register and then the result register.
// Throughput: one word per cycle while out_stall is low; the step core updates phase
// and tick counter once per accepted word, so words may follow back to back.
// Stall: out_stall holds the result register; the input register then holds as
// well and in_stall rises in the same cycle. No word is lost or repeated.
// Reset (rst_n low, synchronous): sequencer idle, counters and held byte cleared,
// pulse_ticks = 1000, settle_ticks = 5000. cfg_ready is always high; a timing write
// takes effect at the next tick. The user must make it only while no word is in
// flight; the block itself does not enforce this.
`default_nettype none

module lcd_nibble_write_sequencer #(
  parameter int unsigned ROW_LENGTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [lcdnw_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [lcdnw_pkg::BYTE_W-1:0]     in_value,
  input  wire logic [lcdnw_pkg::ROW_W-1:0]      in_row,
  input  wire logic [lcdnw_pkg::COL_W-1:0]      in_column,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_reg_select,
  output logic                                  out_read_write,
  output logic                                  out_enable,
  output logic      [lcdnw_pkg::NIB_W-1:0]      out_data_nibble,
  output logic                                  out_busy_res,
  output logic                                  out_rejected,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcdnw_pkg::TICK_W-1:0]     cfg_data
);
  import lcdnw_pkg::*;

  logic                s1_valid_r;
  logic [OPCODE_W-1:0] s1_opcode_r;
  logic [BYTE_W-1:0]   s1_value_r;
  logic [ROW_W-1:0]    s1_row_r;
  logic [COL_W-1:0]    s1_column_r;
  logic                out_valid_r;
  lcdnw_pins_t         out_pins_r;
  lcdnw_pins_t         step_pins;
  logic [TICK_W-1:0]   pulse_ticks_r;
  logic [TICK_W-1:0]   settle_ticks_r;
  logic                out_open;
  logic                s1_adv;
  logic                s1_load;

  assign out_open = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_open;
  assign in_stall = s1_valid_r && !out_open;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_load || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_opcode_r <= in_opcode;
      s1_value_r  <= in_value;
      s1_row_r    <= in_row;
      s1_column_r <= in_column;
    end
  end

  lcdnw_core #(.ROW_LENGTH(ROW_LENGTH)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_adv),
    .opcode       (s1_opcode_r),
    .value        (s1_value_r),
    .row          (s1_row_r),
    .column       (s1_column_r),
    .pulse_ticks  (pulse_ticks_r),
    .settle_ticks (settle_ticks_r),
    .pins         (step_pins)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pins_r <= step_pins;
    end
  end

  // timing registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r  <= PULSE_TICKS_RST;
      settle_ticks_r <= SETTLE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PULSE_TICKS:  pulse_ticks_r  <= cfg_data;
        REG_SETTLE_TICKS: settle_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_select  = out_pins_r.reg_select;
  assign out_read_write  = out_pins_r.read_write;
  assign out_enable      = out_pins_r.enable;
  assign out_data_nibble = out_pins_r.data_nibble;
  assign out_busy_res    = out_pins_r.busy_res;
  assign out_rejected    = out_pins_r.rejected;

endmodule

`default_nettype wire

// ===== verif/lcd_nibble_write_sequencer_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lcd_nibble_write_sequencer: drives tick and request words,
// predicts the LCD pin levels per word, and checks every result word in order.
// Depends on lcdnw_pkg and the lcd_nibble_write_sequencer RTL.

module lcd_nibble_write_sequencer_test;
  import lcdnw_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int ROW_LEN     = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD   = 400;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_HIGH, SEQ_LOW, SEQ_SETTLE} seq_phase_t;

  class pin_tracker;
    seq_phase_t        seq;
    int unsigned       ticks;
    logic [BYTE_W-1:0] held_byte;
    logic              held_select;
    logic [TICK_W-1:0] pulse_cfg;
    logic [TICK_W-1:0] settle_cfg;
    lcdnw_pins_t       pins_due[$];
    int                errors;
    int                words_seen;
    int                requests;
    int                drops;
    int                cursor_moves;

    function new();
      seq = SEQ_IDLE;
      ticks = 0;
      held_byte = '0;
      held_select = 1'b0;
      pulse_cfg = PULSE_TICKS_RST;
      settle_cfg = SETTLE_TICKS_RST;
      errors = 0;
      words_seen = 0;
      requests = 0;
      drops = 0;
      cursor_moves = 0;
    endfunction

    function void set_timing(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
      if (idx == REG_PULSE_TICKS) pulse_cfg = data;
      else if (idx == REG_SETTLE_TICKS) settle_cfg = data;
    endfunction

    function bit idle();
      return seq == SEQ_IDLE;
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    // one accepted word -> pin levels for that tick
    function void take_word(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] val,
                            logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      lcdnw_pins_t p;
      int unsigned pt, st;
      logic [COL_W-1:0] c;
      pt = (pulse_cfg == 0) ? 1 : pulse_cfg;
      st = (settle_cfg == 0) ? 1 : settle_cfg;
      c = (col < ROW_LEN) ? col : '0;
      p = '0;
      p.busy_res = 1'b1;
      if (seq == SEQ_IDLE) begin
        if (op == OP_TICK) begin
          p.busy_res = 1'b0;
          p.data_nibble = held_byte[3:0];
        end else begin
          requests++;
          if (op == OP_LOC) begin
            cursor_moves++;
            if (row == 0) held_byte = ADDR_ROW0 + c;
            else if (row == 1) held_byte = ADDR_ROW1 + c;
            else held_byte = ADDR_ROW0;
          end else begin
            held_byte = val;
          end
          held_select = (op == OP_CHAR);
          p.data_nibble = held_byte[7:4];
          seq = SEQ_HIGH;
          ticks = 0;
        end
      end else begin
        p.rejected = (op != OP_TICK);
        if (p.rejected) drops++;
        case (seq)
          SEQ_HIGH: begin
            p.enable = 1'b1;
            p.data_nibble = held_byte[7:4];
            if (ticks + 1 >= pt) begin
              seq = SEQ_LOW;
              ticks = 0;
            end else ticks++;
          end
          SEQ_LOW: begin
            p.enable = (ticks != 0);
            p.data_nibble = held_byte[3:0];
            if (ticks >= pt) begin
              seq = SEQ_SETTLE;
              ticks = 0;
            end else ticks++;
          end
          default: begin
            p.data_nibble = held_byte[3:0];
            if (ticks + 1 >= st) begin
              seq = SEQ_IDLE;
              ticks = 0;
            end else ticks++;
          end
        endcase
      end
      p.reg_select = held_select;
      p.read_write = 1'b0;
      pins_due.push_back(p);
    endfunction

    function void match_pins(lcdnw_pins_t got);
      lcdnw_pins_t want;
      words_seen++;
      if (pins_due.size() == 0) begin
        errors++;
        if (errors <= 20) $display("%0t: result word with nothing due: %h", $time, got);
        return;
      end
      want = pins_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%0t: pins mismatch exp rs=%b rw=%b en=%b d=%h busy=%b rej=%b", $time,
                   want.reg_select, want.read_write, want.enable, want.data_nibble,
                   want.busy_res, want.rejected,
                   " got rs=%b rw=%b en=%b d=%h busy=%b rej=%b",
                   got.reg_select, got.read_write, got.enable, got.data_nibble,
                   got.busy_res, got.rejected);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_stall;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [BYTE_W-1:0]     in_value;
  logic [ROW_W-1:0]      in_row;
  logic [COL_W-1:0]      in_column;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_reg_select;
  logic                  out_read_write;
  logic                  out_enable;
  logic [NIB_W-1:0]      out_data_nibble;
  logic                  out_busy_res;
  logic                  out_rejected;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [TICK_W-1:0]     cfg_data;

  pin_tracker board;
  int  cycles = 0;
  int  tx_odds = 0;
  int  rx_odds = 0;
  bit  calm = 1'b0;
  bit  hold_rx = 1'b0;

  lcd_nibble_write_sequencer #(.ROW_LENGTH(ROW_LEN)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_value(in_value), .in_row(in_row), .in_column(in_column),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_reg_select(out_reg_select), .out_read_write(out_read_write),
    .out_enable(out_enable), .out_data_nibble(out_data_nibble),
    .out_busy_res(out_busy_res), .out_rejected(out_rejected),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("lcd_nibble_write_sequencer_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_pins({out_reg_select, out_read_write, out_enable, out_data_nibble,
                        out_busy_res, out_rejected});
  end

  // result side back-pressure
  initial begin : rx_side
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_rx = 1'b0;
      end else if (!calm && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_word(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] val,
                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int n;
    if (!calm && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 17);
      repeat (n) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    in_row    <= row;
    in_column <= col;
    do @(posedge clk); while (in_stall);
    board.take_word(op, val, row, col);
  endtask

  task automatic push_tick();
    push_word(OP_TICK, BYTE_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic push_request();
    push_word(OPCODE_W'($urandom_range(OP_CMD, OP_LOC)), BYTE_W'($urandom),
              ROW_W'($urandom), COL_W'($urandom));
  endtask

  // tick until the sequence returns to idle; drop_odds 0 means no requests in between
  task automatic run_out_sequence(int drop_odds);
    while (!board.idle()) begin
      if (drop_odds != 0 && $urandom_range(1, drop_odds) == 1) push_request();
      else push_tick();
    end
  endtask

  // a given number of words, ticks with requests mixed in at drop_odds, part of a long sequence
  task automatic run_some(int n_words, int drop_odds);
    int k;
    for (k = 0; k < n_words; k++) begin
      if (drop_odds != 0 && $urandom_range(1, drop_odds) == 1) push_request();
      else push_tick();
    end
  endtask

  task automatic issue(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] val,
                       logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    push_word(op, val, row, col);
    run_out_sequence(0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic quiesce();
    run_out_sequence(0);
    drain_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timing(logic [TICK_W-1:0] pulse, logic [TICK_W-1:0] settle);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PULSE_TICKS;
    cfg_data  <= pulse;
    do @(posedge clk); while (!cfg_ready);
    board.set_timing(REG_PULSE_TICKS, pulse);
    cfg_index <= REG_SETTLE_TICKS;
    cfg_data  <= settle;
    do @(posedge clk); while (!cfg_ready);
    board.set_timing(REG_SETTLE_TICKS, settle);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_run(int n_words);
    int k;
    for (k = 0; k < n_words; k++) begin
      if (board.idle()) begin
        if ($urandom_range(0, 9) == 0) push_tick();
        else push_request();
      end else if ($urandom_range(0, 7) == 0) push_request();
      else push_tick();
    end
  endtask

  task automatic random_phase(logic [TICK_W-1:0] pulse, logic [TICK_W-1:0] settle,
                              int tx, int rx, int n_words);
    quiesce();
    write_timing(pulse, settle);
    tx_odds = tx;
    rx_odds = rx;
    random_run(n_words);
  endtask

  initial begin
    board = new();
    in_valid  <= 1'b0;
    in_opcode <= OP_TICK;
    in_value  <= '0;
    in_row    <= '0;
    in_column <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PULSE_TICKS;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing, with requests dropped along the way; shortened mid-pulse
    tx_odds = 8;
    rx_odds = 8;
    push_word(OP_CMD, 8'h28, '0, '0);
    run_some(100, 50);
    drain_results();
    write_timing(16'd1, 16'd1);
    quiesce();

    // directed at the shortest timing
    write_timing(16'd1, 16'd1);
    push_tick();
    issue(OP_CMD, 8'h00, '0, '0);
    push_word(OP_CHAR, 8'hFF, '0, '0);
    push_word(OP_LOC, 8'h3C, 2'd1, 6'd5);
    run_out_sequence(0);
    issue(OP_LOC, 8'h00, 2'd0, 6'd15);
    issue(OP_LOC, 8'hFF, 2'd1, 6'd63);
    issue(OP_LOC, 8'h00, 2'd3, 6'd42);

    random_phase(16'd0, 16'd0, 4, 4, 120);
    hold_rx = 1'b1;
    random_phase(16'd3, 16'd2, 0, 0, 120);
    random_phase(TICK_W'($urandom_range(1, 5)), TICK_W'($urandom_range(1, 5)), 10, 3, 100);
    drain_results();
    random_run(100);
    random_phase(16'd1, 16'd40, 3, 10, 120);
    random_phase(16'd7, 16'd1, 0, 6, 120);
    random_phase(16'd2, 16'd2, 6, 0, 120);

    // full-scale timing, no idling from here on
    quiesce();
    calm = 1'b1;
    write_timing(16'hFFFF, 16'hFFFF);
    push_request();
    run_some(150, 20);
    drain_results();
    write_timing(16'd2, 16'd3);
    run_out_sequence(0);
    push_tick();
    drain_results();
    repeat (4) @(posedge clk);

    $display("covered %0d result words: %0d requests taken, %0d dropped while busy,",
             board.words_seen, board.requests, board.drops);
    $display("%0d cursor moves, timing from zero to full scale on both registers",
             board.cursor_moves);
    if (board.errors == 0) begin
      $display("lcd_nibble_write_sequencer_test: done, clean");
    end else begin
      $display("lcd_nibble_write_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule
